// File: rtl/emrb_pkg.sv
package emrb_pkg;

    localparam int RX_QUEUES_DEF = 4;
    localparam int TX_QUEUES_DEF = 2;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RX    = 2'd2,
        KIND_TX    = 2'd3
    } t_kind;

    // register byte offsets
    localparam logic [11:0] OFF_MGMT  = 12'h010;
    localparam logic [11:0] OFF_PORT  = 12'h408;
    localparam logic [11:0] OFF_CMD   = 12'h448;
    localparam logic [11:0] OFF_CAUSE = 12'h450;
    localparam logic [11:0] OFF_MASK  = 12'h458;
    // window bases, upper offset bits only
    localparam logic [7:0]  WIN_FIRST = 8'h48;  // 0x480..0x48F
    localparam logic [7:0]  WIN_HEAD  = 8'h4A;  // 0x4A0..0x4AF
    localparam logic [8:0]  WIN_TXH   = 9'h09C; // 0x4E0..0x4E7

    localparam int          MGMT_READ_BIT = 26;
    localparam logic [31:0] MGMT_VALID    = 32'h0800_0000;
    localparam logic [31:0] MGMT_ADDR     = 32'h03FF_0000;
    localparam logic [31:0] PHY_STATUS    = 32'h0021_0000;
    localparam logic [31:0] PHY_ID1       = 32'h0041_0000;
    localparam logic [31:0] PHY_ID2       = 32'h0061_0000;
    localparam logic [31:0] PHY_ID_WORD   = 32'h0141_0E20;
    localparam logic [31:0] STATUS_LINK   = 32'h0000_0004;
    localparam logic [31:0] STATUS_ANEG   = 32'h0000_0008;
    localparam int          CMD_TX_HIGH_BIT = 23;
    localparam int          CMD_TX_LOW_BIT  = 22;
    localparam int          PORT_SUFFIX_BIT = 28;

    localparam int IN_TDATA_W  = 80; // 78 bits of fields, padded
    localparam int OUT_TDATA_W = 72; // 69 bits of fields, padded

    // answer of the management word on a read
    function automatic logic [31:0] mgmt_read(input logic [31:0] w);
        logic [31:0] r;
        if (!w[MGMT_READ_BIT]) begin
            r = '0;
        end else begin
            case (w & MGMT_ADDR)
                PHY_STATUS: r = STATUS_LINK | STATUS_ANEG | MGMT_VALID;
                PHY_ID1:    r = (PHY_ID_WORD >> 16) | MGMT_VALID;
                PHY_ID2:    r = (PHY_ID_WORD & 32'h0000_FFFF) | MGMT_VALID;
                default:    r = MGMT_VALID;
            endcase
        end
        return r;
    endfunction

endpackage

// File: rtl/eth_mac_register_block.sv
// Register front end of an Ethernet MAC. Each input transfer is a bus read,
// a bus write, an rx-frame-stored event or a tx-descriptor-done event
// (selected by tuser); each yields exactly one output transfer carrying the
// read data, the interrupt level (cause AND mask, after the update), the tx
// start request of a command write, the current rx descriptor pointer of the
// addressed queue and the rx suffix byte count. One item per cycle is
// accepted back to back while the output is not back-pressured; each item
// passes the registered read of the pointer memories (stage 1) and then
// the output register. The ring pointers live in two small synchronous
// memories (bus-only pointers, and the rx current pointers that events also
// update); a write bypass covers a read issued at the same edge as the
// preceding item's write-back. Per-entry valid bits make every pointer read
// zero after reset, so no clearing pass is needed. Scalar registers sit in
// flops and are updated in item order at the write-back stage.
module eth_mac_register_block #(
    parameter int RX_QUEUES = emrb_pkg::RX_QUEUES_DEF,
    parameter int TX_QUEUES = emrb_pkg::TX_QUEUES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [11:0] offset, [43:12] write_data, [45:44] queue, [77:46] rx_link
    input  logic [emrb_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] kind
    input  logic [1:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] read_data, [32] irq, [34:33] tx_request, [66:35] rx_desc_ptr,
    // [68:67] suffix_bytes
    output logic [emrb_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int RXW       = (RX_QUEUES > 1) ? $clog2(RX_QUEUES) : 1;
    localparam int PTR_DEPTH = 2 * RX_QUEUES + TX_QUEUES;
    localparam int PAW       = $clog2(PTR_DEPTH);

    typedef struct packed {
        logic mgmt;
        logic port;
        logic cmd;
        logic cause;
        logic mask;
        logic first;
        logic head;
        logic txh;
    } t_dec;

    // ---------------- input unpack and decode ----------------
    logic [11:0] in_off;
    logic [31:0] in_data;
    logic [1:0]  in_q;
    logic [31:0] in_link;
    t_dec        in_dec;
    logic [PAW-1:0] in_paddr;

    assign in_off  = i_s_tdata[11:0];
    assign in_data = i_s_tdata[43:12];
    assign in_q    = i_s_tdata[45:44];
    assign in_link = i_s_tdata[77:46];

    always_comb begin
        in_dec.mgmt  = (in_off == emrb_pkg::OFF_MGMT);
        in_dec.port  = (in_off == emrb_pkg::OFF_PORT);
        in_dec.cmd   = (in_off == emrb_pkg::OFF_CMD);
        in_dec.cause = (in_off == emrb_pkg::OFF_CAUSE);
        in_dec.mask  = (in_off == emrb_pkg::OFF_MASK);
        in_dec.first = (in_off[11:4] == emrb_pkg::WIN_FIRST)
                       && (3'(in_off[3:2]) < 3'(RX_QUEUES));
        in_dec.head  = (in_off[11:4] == emrb_pkg::WIN_HEAD)
                       && (3'(in_off[3:2]) < 3'(RX_QUEUES));
        in_dec.txh   = (in_off[11:3] == emrb_pkg::WIN_TXH)
                       && (2'(in_off[2]) < 2'(TX_QUEUES));
        // pointer memory layout: first ptrs, ring heads, tx heads
        if (in_dec.first) begin
            in_paddr = PAW'(in_off[3:2]);
        end else if (in_dec.head) begin
            in_paddr = PAW'(RX_QUEUES) + PAW'(in_off[3:2]);
        end else if (in_dec.txh) begin
            in_paddr = PAW'(2 * RX_QUEUES) + PAW'(in_off[2]);
        end else begin
            in_paddr = '0;
        end
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic advance;
    logic accept;
    logic commit;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || advance;
    assign accept     = i_s_tvalid && o_s_tready;
    assign commit     = r_s1_valid && advance;

    // ---------------- stage 1 registers ----------------
    emrb_pkg::t_kind r_s1_kind;
    t_dec            r_s1_dec;
    logic [PAW-1:0]  r_s1_paddr;
    logic [RXW-1:0]  r_s1_hidx;
    logic [31:0]     r_s1_data;
    logic [1:0]      r_s1_q;
    logic [31:0]     r_s1_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= emrb_pkg::t_kind'(i_s_tuser);
            r_s1_dec   <= in_dec;
            r_s1_paddr <= in_paddr;
            r_s1_hidx  <= in_off[RXW+1:2];
            r_s1_data  <= in_data;
            r_s1_q     <= in_q;
            r_s1_link  <= in_link;
        end
    end

    // ---------------- pointer memories ----------------
    logic [31:0]          ptr_mem [PTR_DEPTH];
    logic [PTR_DEPTH-1:0] r_ptr_vld;
    logic [31:0]          r_ptr_rd;
    logic                 r_ptr_rv;
    logic [31:0]          cur_mem [RX_QUEUES];
    logic [RX_QUEUES-1:0] r_cur_vld;
    logic [31:0]          r_cur_rd;
    logic                 r_cur_rv;

    // last write of each memory, for the read issued at the same edge
    logic                 r_pfw_v;
    logic [PAW-1:0]       r_pfw_addr;
    logic [31:0]          r_pfw_data;
    logic                 r_cfw_v;
    logic [RXW-1:0]       r_cfw_addr;
    logic [31:0]          r_cfw_data;

    logic                 ptr_we;
    logic                 cur_we;
    logic [RXW-1:0]       cur_wa;
    logic [31:0]          cur_wd;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ptr_rd <= ptr_mem[in_paddr];
            r_ptr_rv <= r_ptr_vld[in_paddr];
            r_cur_rd <= cur_mem[in_q[RXW-1:0]];
            r_cur_rv <= r_cur_vld[in_q[RXW-1:0]];
        end
        if (commit && ptr_we) begin
            ptr_mem[r_s1_paddr] <= r_s1_data;
        end
        if (commit && cur_we) begin
            cur_mem[cur_wa] <= cur_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_vld <= '0;
            r_cur_vld <= '0;
            r_pfw_v   <= 1'b0;
            r_cfw_v   <= 1'b0;
        end else begin
            if (commit && ptr_we) begin
                r_ptr_vld[r_s1_paddr] <= 1'b1;
                r_pfw_v               <= 1'b1;
            end
            if (commit && cur_we) begin
                r_cur_vld[cur_wa] <= 1'b1;
                r_cfw_v           <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && ptr_we) begin
            r_pfw_addr <= r_s1_paddr;
            r_pfw_data <= r_s1_data;
        end
        if (commit && cur_we) begin
            r_cfw_addr <= cur_wa;
            r_cfw_data <= cur_wd;
        end
    end

    // ---------------- scalar registers ----------------
    logic [31:0] r_mgmt;
    logic [31:0] r_cause;
    logic [31:0] r_mask;
    logic        r_suffix;
    logic [31:0] n_mgmt;
    logic [31:0] n_cause;
    logic [31:0] n_mask;
    logic        n_suffix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mgmt   <= '0;
            r_cause  <= '0;
            r_mask   <= '0;
            r_suffix <= 1'b0;
        end else if (commit) begin
            r_mgmt   <= n_mgmt;
            r_cause  <= n_cause;
            r_mask   <= n_mask;
            r_suffix <= n_suffix;
        end
    end

    // ---------------- stage 1 execute ----------------
    logic        is_rd;
    logic        is_wr;
    logic        is_rx;
    logic        is_tx;
    logic        q_rx_ok;
    logic        q_tx_ok;
    logic [31:0] p_data;
    logic [31:0] c_data;
    logic [31:0] res_rd;
    logic [1:0]  res_req;
    logic [31:0] res_ptr;

    always_comb begin
        is_rd   = (r_s1_kind == emrb_pkg::KIND_READ);
        is_wr   = (r_s1_kind == emrb_pkg::KIND_WRITE);
        is_rx   = (r_s1_kind == emrb_pkg::KIND_RX);
        is_tx   = (r_s1_kind == emrb_pkg::KIND_TX);
        q_rx_ok = (3'(r_s1_q) < 3'(RX_QUEUES));
        q_tx_ok = (3'(r_s1_q) < 3'(TX_QUEUES));

        // bypass the write that landed at the read edge
        if (r_pfw_v && (r_pfw_addr == r_s1_paddr)) begin
            p_data = r_pfw_data;
        end else begin
            p_data = r_ptr_rv ? r_ptr_rd : '0;
        end
        if (r_cfw_v && (r_cfw_addr == r_s1_q[RXW-1:0])) begin
            c_data = r_cfw_data;
        end else begin
            c_data = r_cur_rv ? r_cur_rd : '0;
        end

        ptr_we = is_wr && (r_s1_dec.first || r_s1_dec.head || r_s1_dec.txh);
        cur_we = (is_wr && r_s1_dec.head) || (is_rx && q_rx_ok);
        cur_wa = is_rx ? r_s1_q[RXW-1:0] : r_s1_hidx;
        cur_wd = is_rx ? r_s1_link : r_s1_data;

        n_mgmt   = (is_wr && r_s1_dec.mgmt) ? r_s1_data : r_mgmt;
        n_mask   = (is_wr && r_s1_dec.mask) ? r_s1_data : r_mask;
        n_suffix = (is_wr && r_s1_dec.port) ? r_s1_data[emrb_pkg::PORT_SUFFIX_BIT]
                                            : r_suffix;
        n_cause  = r_cause;
        if (is_wr && r_s1_dec.cause) begin
            n_cause = r_cause & r_s1_data;
        end else if (is_rx && q_rx_ok) begin
            n_cause = r_cause | 32'h1;
        end else if (is_tx && q_tx_ok) begin
            // low queue raises bit 3, high queue bit 2
            n_cause = r_cause | (32'h8 >> r_s1_q);
        end

        res_req = '0;
        if (is_wr && r_s1_dec.cmd) begin
            res_req[1] = r_s1_data[emrb_pkg::CMD_TX_HIGH_BIT] && (TX_QUEUES > 1);
            res_req[0] = r_s1_data[emrb_pkg::CMD_TX_LOW_BIT];
        end

        res_rd = '0;
        if (is_rd) begin
            if (r_s1_dec.mgmt) begin
                res_rd = emrb_pkg::mgmt_read(r_mgmt);
            end else if (r_s1_dec.cause) begin
                res_rd = r_cause;
            end else if (r_s1_dec.mask) begin
                res_rd = r_mask;
            end else if (r_s1_dec.first || r_s1_dec.head || r_s1_dec.txh) begin
                res_rd = p_data;
            end
        end

        if (!q_rx_ok) begin
            res_ptr = '0;
        end else if (cur_we && (cur_wa == r_s1_q[RXW-1:0])) begin
            res_ptr = cur_wd;
        end else begin
            res_ptr = c_data;
        end
    end

    // ---------------- output register ----------------
    logic [68:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= {n_suffix, 1'b0, res_ptr, res_req, |(n_cause & n_mask), res_rd};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(emrb_pkg::OUT_TDATA_W - 69){1'b0}}, r_out};

    // ---------------- assertions ----------------
    // a finished item always reaches the output register
    a_commit_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("item left stage 1 without an output transfer");

    // an empty execute stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_s_tready)
        else $error("input stalled with stage 1 empty");

    // a tx request comes only from a write, which never carries read data
    a_req_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out[34:33] != 2'b00)) |-> (r_out[31:0] == 32'h0))
        else $error("tx request with nonzero read data");

    // a write to the ring head shows up as the current pointer of that queue
    a_head_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && is_wr && r_s1_dec.head && (r_s1_hidx == r_s1_q[RXW-1:0])
         && q_rx_ok) |=> (r_out[66:35] == $past(r_s1_data)))
        else $error("ring head write not reflected in rx pointer");

endmodule
